// ===== sv/enc_pkg.sv =====
// ----------------------------------------------------------------------------
// enc_pkg
// Shared types and constants of the epsilon-NFA to NFA converter.
// ----------------------------------------------------------------------------
package enc_pkg;

    localparam int MAX_STATES_DEF  = 16;
    localparam int CMD_W           = 2;
    localparam int STATE_W         = 4;
    localparam int SYM_W           = 2;
    localparam int MASK_W          = 16;
    localparam int COUNT_W         = 5;
    localparam int STATE_COUNT_RST = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_CONVERT = 2'd2
    } t_cmd;

    typedef enum logic [SYM_W-1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_EPS  = 2'd2
    } t_sym;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOS_INIT,
        S_CLOS_SWEEP,
        S_CLOS_STORE,
        S_ROW_INIT,
        S_ROW_MOVE,
        S_ROW_CLOSE,
        S_ROW_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic add;
        logic start;
        logic clos_init;
        logic clos_step;
        logic clos_store;
        logic row_init;
        logic move_step;
        logic close_step;
        logic next_row;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic k_last;
        logic i_last;
        logic chg_any;
    } t_dp_sts;

endpackage

// ===== sv/enc_if.sv =====
// ----------------------------------------------------------------------------
// enc_if
// Valid/ready channels of the converter: input items, result rows, config.
// ----------------------------------------------------------------------------
interface enc_in_if;
    logic                        valid;
    logic                        ready;
    logic [enc_pkg::CMD_W-1:0]   cmd;
    logic [enc_pkg::STATE_W-1:0] src_state;
    logic [enc_pkg::SYM_W-1:0]   symbol;
    logic [enc_pkg::STATE_W-1:0] dst_state;

    modport source (output valid, cmd, src_state, symbol, dst_state, input ready);
    modport sink   (input valid, cmd, src_state, symbol, dst_state, output ready);
endinterface

interface enc_out_if;
    logic                        valid;
    logic                        ready;
    logic [enc_pkg::STATE_W-1:0] row_state;
    logic [enc_pkg::MASK_W-1:0]  closure_mask;
    logic [enc_pkg::MASK_W-1:0]  next_on_zero;
    logic [enc_pkg::MASK_W-1:0]  next_on_one;
    logic                        last;

    modport source (output valid, row_state, closure_mask, next_on_zero, next_on_one, last,
                    input ready);
    modport sink   (input valid, row_state, closure_mask, next_on_zero, next_on_one, last,
                    output ready);
endinterface

interface enc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [enc_pkg::COUNT_W-1:0] state_count;

    modport source (output valid, state_count, input ready);
    modport sink   (input valid, state_count, output ready);
endinterface

// ===== sv/enc_ctrl.sv =====
// ----------------------------------------------------------------------------
// enc_ctrl
// Sequencer for loading, closure sweeps and per-state result rows.
// ----------------------------------------------------------------------------
module enc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [enc_pkg::CMD_W-1:0] i_in_cmd,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  enc_pkg::t_dp_sts          i_sts,
    output enc_pkg::t_dp_cmd          o_cmd
);

    enc_pkg::t_state r_state;
    enc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= enc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            enc_pkg::S_IDLE: begin
                if (i_in_valid && i_in_cmd == enc_pkg::CMD_CONVERT) begin
                    n_state = enc_pkg::S_CLOS_INIT;
                end
            end
            enc_pkg::S_CLOS_INIT: begin
                n_state = enc_pkg::S_CLOS_SWEEP;
            end
            enc_pkg::S_CLOS_SWEEP: begin
                // stop after a full sweep that added nothing
                if (i_sts.k_last && !i_sts.chg_any) begin
                    n_state = enc_pkg::S_CLOS_STORE;
                end
            end
            enc_pkg::S_CLOS_STORE: begin
                n_state = i_sts.i_last ? enc_pkg::S_ROW_INIT : enc_pkg::S_CLOS_INIT;
            end
            enc_pkg::S_ROW_INIT: begin
                n_state = enc_pkg::S_ROW_MOVE;
            end
            enc_pkg::S_ROW_MOVE: begin
                if (i_sts.k_last) begin
                    n_state = enc_pkg::S_ROW_CLOSE;
                end
            end
            enc_pkg::S_ROW_CLOSE: begin
                if (i_sts.k_last) begin
                    n_state = enc_pkg::S_ROW_OUT;
                end
            end
            enc_pkg::S_ROW_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.i_last ? enc_pkg::S_IDLE : enc_pkg::S_ROW_INIT;
                end
            end
            default: begin
                n_state = enc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            enc_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.clear   = i_in_valid && i_in_cmd == enc_pkg::CMD_CLEAR;
                o_cmd.add     = i_in_valid && i_in_cmd == enc_pkg::CMD_ADD;
                o_cmd.start   = i_in_valid && i_in_cmd == enc_pkg::CMD_CONVERT;
            end
            enc_pkg::S_CLOS_INIT:  o_cmd.clos_init  = 1'b1;
            enc_pkg::S_CLOS_SWEEP: o_cmd.clos_step  = 1'b1;
            enc_pkg::S_CLOS_STORE: o_cmd.clos_store = 1'b1;
            enc_pkg::S_ROW_INIT:   o_cmd.row_init   = 1'b1;
            enc_pkg::S_ROW_MOVE:   o_cmd.move_step  = 1'b1;
            enc_pkg::S_ROW_CLOSE:  o_cmd.close_step = 1'b1;
            enc_pkg::S_ROW_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.next_row = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/enc_dp.sv =====
// ----------------------------------------------------------------------------
// enc_dp
// Transition tables, closure rows, sweep counters and result registers.
// ----------------------------------------------------------------------------
module enc_dp #(
    parameter int MAX_STATES = enc_pkg::MAX_STATES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  enc_pkg::t_dp_cmd            i_cmd,
    output enc_pkg::t_dp_sts            o_sts,
    input  logic [enc_pkg::STATE_W-1:0] i_src,
    input  logic [enc_pkg::SYM_W-1:0]   i_sym,
    input  logic [enc_pkg::STATE_W-1:0] i_dst,
    input  logic                        i_cfg_wr,
    input  logic [enc_pkg::COUNT_W-1:0] i_cfg_data,
    output logic [enc_pkg::STATE_W-1:0] o_row_state,
    output logic [enc_pkg::MASK_W-1:0]  o_closure_mask,
    output logic [enc_pkg::MASK_W-1:0]  o_next_on_zero,
    output logic [enc_pkg::MASK_W-1:0]  o_next_on_one,
    output logic                        o_last
);

    localparam int ROW = (MAX_STATES < enc_pkg::MASK_W) ? MAX_STATES : enc_pkg::MASK_W;
    localparam int IW  = $clog2(ROW);
    localparam int CW  = $clog2(ROW + 1);

    logic [ROW-1:0] r_zero [ROW];
    logic [ROW-1:0] r_one  [ROW];
    logic [ROW-1:0] r_eps  [ROW];
    logic [ROW-1:0] r_clos [ROW];

    logic [enc_pkg::COUNT_W-1:0] r_cnt;
    logic [CW-1:0]               r_n;
    logic [ROW-1:0]              r_um;
    logic [IW-1:0]               r_i;
    logic [IW-1:0]               r_k;
    logic                        r_chg;

    logic [ROW-1:0] r_acc;
    logic [ROW-1:0] r_zm;
    logic [ROW-1:0] r_om;
    logic [ROW-1:0] r_zc;
    logic [ROW-1:0] r_oc;

    logic [CW-1:0]  n_n;
    logic [ROW-1:0] n_um;
    logic [ROW-1:0] dst_oh;
    logic [ROW-1:0] clos_grow;
    logic [ROW-1:0] clos_next;
    logic           step_chg;
    logic [ROW-1:0] clos_k;
    logic           k_last;
    logic           i_last;

    // states in use: zero counts as one, saturate at the row limit
    always_comb begin
        if (r_cnt == '0) begin
            n_n = CW'(1);
        end else if (int'(r_cnt) > ROW) begin
            n_n = CW'(ROW);
        end else begin
            n_n = CW'(r_cnt);
        end
        for (int j = 0; j < ROW; j++) begin
            n_um[j]   = (j < int'(n_n));
            dst_oh[j] = (int'(i_dst) == j);
        end
    end

    assign k_last = (CW'(r_k) == r_n - CW'(1));
    assign i_last = (CW'(r_i) == r_n - CW'(1));

    assign clos_grow = r_acc | (r_eps[r_k] & r_um);
    assign clos_next = r_acc[r_k] ? clos_grow : r_acc;
    assign step_chg  = (clos_next != r_acc);
    assign clos_k    = r_clos[r_k];

    assign o_sts.k_last  = k_last;
    assign o_sts.i_last  = i_last;
    assign o_sts.chg_any = r_chg | step_chg;

    // transition tables, cleared by reset and by the clear command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int r = 0; r < ROW; r++) begin
                r_zero[r] <= '0;
                r_one[r]  <= '0;
                r_eps[r]  <= '0;
            end
        end else if (i_cmd.add) begin
            for (int r = 0; r < ROW; r++) begin
                if (int'(i_src) == r) begin
                    if (i_sym == enc_pkg::SYM_ZERO) begin
                        r_zero[r] <= r_zero[r] | dst_oh;
                    end
                    if (i_sym == enc_pkg::SYM_ONE) begin
                        r_one[r] <= r_one[r] | dst_oh;
                    end
                    if (i_sym == enc_pkg::SYM_EPS) begin
                        r_eps[r] <= r_eps[r] | dst_oh;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= enc_pkg::COUNT_W'(enc_pkg::STATE_COUNT_RST);
            r_n   <= CW'(1);
            r_um  <= '0;
            r_i   <= '0;
            r_k   <= '0;
            r_chg <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cnt <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_n  <= n_n;
                r_um <= n_um;
                r_i  <= '0;
            end
            if (i_cmd.clos_init || i_cmd.row_init) begin
                r_k   <= '0;
                r_chg <= 1'b0;
            end
            if (i_cmd.clos_step) begin
                r_k   <= k_last ? '0 : r_k + IW'(1);
                r_chg <= k_last ? 1'b0 : (r_chg | step_chg);
            end
            if (i_cmd.move_step || i_cmd.close_step) begin
                r_k <= k_last ? '0 : r_k + IW'(1);
            end
            if (i_cmd.clos_store || i_cmd.next_row) begin
                r_i <= i_last ? '0 : r_i + IW'(1);
            end
        end
    end

    // closure rows and row accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.clos_init) begin
            for (int j = 0; j < ROW; j++) begin
                r_acc[j] <= (int'(r_i) == j);
            end
        end
        if (i_cmd.clos_step) begin
            r_acc <= clos_next;
        end
        if (i_cmd.clos_store) begin
            r_clos[r_i] <= r_acc;
        end
        if (i_cmd.row_init) begin
            r_acc <= r_clos[r_i];
            r_zm  <= '0;
            r_om  <= '0;
            r_zc  <= '0;
            r_oc  <= '0;
        end
        if (i_cmd.move_step && r_acc[r_k]) begin
            r_zm <= r_zm | (r_zero[r_k] & r_um);
            r_om <= r_om | (r_one[r_k] & r_um);
        end
        if (i_cmd.close_step) begin
            if (r_zm[r_k]) begin
                r_zc <= r_zc | clos_k;
            end
            if (r_om[r_k]) begin
                r_oc <= r_oc | clos_k;
            end
        end
    end

    assign o_row_state    = enc_pkg::STATE_W'(r_i);
    assign o_closure_mask = enc_pkg::MASK_W'(r_acc);
    assign o_next_on_zero = enc_pkg::MASK_W'(r_zc);
    assign o_next_on_one  = enc_pkg::MASK_W'(r_oc);
    assign o_last         = i_last;

endmodule

// ===== sv/epsilon_nfa_to_nfa_converter.sv =====
// ----------------------------------------------------------------------------
// epsilon_nfa_to_nfa_converter
// Epsilon-NFA loader and converter to epsilon-free NFA rows.
// ----------------------------------------------------------------------------
// Clear and add items are taken while idle and the block stays ready for the
// next item. A convert item, with n states in use, first builds each closure
// by sweeping the epsilon table one row a cycle until a sweep adds nothing,
// then for each state loads its closure and runs the move and closure sweeps
// before its row is shown; the next row starts when the row is taken. Each
// sweep reads one table row per cycle. No input is taken until the last row
// is taken.
module epsilon_nfa_to_nfa_converter #(
    parameter int MAX_STATES = enc_pkg::MAX_STATES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    enc_in_if.sink     i_in,
    enc_out_if.source  o_out,
    enc_cfg_if.sink    i_cfg
);

    enc_pkg::t_dp_cmd dp_cmd;
    enc_pkg::t_dp_sts dp_sts;

    assign i_cfg.ready = 1'b1;

    enc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    enc_dp #(
        .MAX_STATES (MAX_STATES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_src          (i_in.src_state),
        .i_sym          (i_in.symbol),
        .i_dst          (i_in.dst_state),
        .i_cfg_wr       (i_cfg.valid && i_cfg.ready),
        .i_cfg_data     (i_cfg.state_count),
        .o_row_state    (o_out.row_state),
        .o_closure_mask (o_out.closure_mask),
        .o_next_on_zero (o_out.next_on_zero),
        .o_next_on_one  (o_out.next_on_one),
        .o_last         (o_out.last)
    );

    // no new transaction while a row is pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result row is pending");

    // a closure always holds its own state
    a_self_in_closure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.closure_mask[o_out.row_state])
        else $error("closure row lacks its own state");

    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == enc_pkg::CMD_CONVERT) |=> !i_in.ready)
        else $error("ready right after a convert transaction");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (!o_out.valid && i_in.ready))
        else $error("rows continue after the last row");

endmodule
